@@ design/hmls_pkg.sv @@
// Shared types, constants and per-character line scan functions for the
// HTTP message length scanner. No dependencies.
`default_nettype none

package hmls_pkg;

   localparam int HeaderCountBitsDefault = 32;
   localparam int MaxValueCharsDefault   = 23;
   localparam int NameLen                = 15;
   localparam int LinePosMax             = 16;
   localparam int DigitsMax              = 31;

   localparam logic [62:0]          ValueLimit = '1;
   localparam logic [8*NameLen-1:0] LengthName = "content-length:";
   localparam logic [31:0]          HeaderEnd  = 32'h0D0A_0D0A;

   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChUpA   = 8'h41;
   localparam logic [7:0] ChUpZ   = 8'h5A;
   localparam logic [7:0] CaseBit = 8'h20;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [4:0]  pos;
      logic        matching;
      phase_type   phase;
      logic [4:0]  digits;
      logic [62:0] acc;
      logic        bad;
   } line_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_message;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [63:0] total_length;
   } rsp_payload_type;

   function automatic line_type line_clear();
      line_type r;
      r.pos      = '0;
      r.matching = 1'b1;
      r.phase    = PH_LEAD;
      r.digits   = '0;
      r.acc      = '0;
      r.bad      = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] name_char(logic [3:0] p);
      return LengthName[8*(NameLen-1-int'(p)) +: 8];
   endfunction

   // A held-back CR that is not followed by LF: never a name character,
   // never blank, never a digit.
   function automatic line_type line_cr(line_type s, logic length_found);
      line_type r;
      r = s;
      if (s.pos < 5'(NameLen)) begin
         r.matching = 1'b0;
      end else if (s.matching && !length_found) begin
         if (s.phase != PH_TRAIL) begin
            r.phase = PH_DIGITS;
            if (s.digits < 5'(DigitsMax)) begin
               r.digits = s.digits + 5'd1;
            end
         end
         r.bad = 1'b1;
      end
      if (s.pos < 5'(LinePosMax)) begin
         r.pos = s.pos + 5'd1;
      end
      return r;
   endfunction

   function automatic line_type line_char(line_type s, logic [7:0] c,
                                          logic length_found,
                                          logic [4:0] max_chars);
      line_type    r;
      logic [7:0]  lc;
      logic        blank;
      logic        digit;
      logic [4:0]  cnt;
      logic [67:0] wide;
      r     = s;
      lc    = (c >= ChUpA && c <= ChUpZ) ? (c | CaseBit) : c;
      blank = (c == ChSpace) || (c == ChTab);
      digit = (c >= ChZero) && (c <= ChNine);
      cnt   = (s.digits < 5'(DigitsMax)) ? s.digits + 5'd1 : s.digits;
      // acc * 10 + digit; acc never exceeds the limit, so 68 bits hold it
      wide  = ({5'b0, s.acc} << 3) + ({5'b0, s.acc} << 1) + 68'(c - ChZero);
      if (s.pos < 5'(NameLen)) begin
         if (lc != name_char(s.pos[3:0])) begin
            r.matching = 1'b0;
         end
      end else if (s.matching && !length_found) begin
         case (s.phase)
            PH_TRAIL: begin
               if (!blank) begin
                  r.bad = 1'b1;
               end
            end
            PH_LEAD, PH_DIGITS: begin
               if (blank) begin
                  if (s.phase == PH_DIGITS) begin
                     r.phase = PH_TRAIL;
                  end
               end else begin
                  r.phase  = PH_DIGITS;
                  r.digits = cnt;
                  if (cnt > max_chars) begin
                     r.bad = 1'b1;
                  end
                  if (!digit) begin
                     r.bad = 1'b1;
                  end else if (wide[67:63] != 5'd0) begin
                     r.bad = 1'b1;
                     r.acc = ValueLimit;
                  end else begin
                     r.acc = wide[62:0];
                  end
               end
            end
            default: begin
               r.bad = 1'b1;
            end
         endcase
      end
      if (s.pos < 5'(LinePosMax)) begin
         r.pos = s.pos + 5'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/http_message_length_scanner.sv @@
// HTTP/1.1 message length scanner, top level.
// Depends on hmls_pkg (types, constants, line scan functions).
`default_nettype none

// Takes one message byte per req beat (first_of_message restarts the scan)
// and, on the beat that completes the first CR LF CR LF, emits one rsp beat:
// status 0 with total_length = header bytes (blank line included) plus the
// Content-Length value, or status 1 with total_length 0 when the first
// "Content-Length:" line is malformed (empty, non-digit, too many characters,
// above 2^63-1) or the header byte count overflows HEADER_COUNT_BITS. A
// message without a length line reports its header length alone. Bytes
// after the result are dropped until the next first_of_message beat; out of
// reset a message is taken to be in progress. Throughput is one byte per
// clock: each beat is folded into the scan state by one level of logic
// (name compare, blank/digit classify, one multiply-by-ten add) in the same
// cycle it is accepted. The result sits in an output register with a
// one-entry skid behind it, so bytes keep flowing while a result waits;
// req_ready drops only when both hold a result.
module http_message_length_scanner #(
   parameter int HEADER_COUNT_BITS = hmls_pkg::HeaderCountBitsDefault,
   parameter int MAX_VALUE_CHARS   = hmls_pkg::MaxValueCharsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire hmls_pkg::req_payload_type req_payload,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      hmls_pkg::rsp_payload_type rsp_payload
);

   import hmls_pkg::*;

   // scan state
   logic [23:0]              recent_ff,    recent_in;
   logic [HEADER_COUNT_BITS:0] hdr_cnt_ff, hdr_cnt_in;
   logic                     done_ff,      done_in;
   line_type                 line_ff,      line_in;
   logic                     found_ff,     found_in;
   logic [62:0]              body_ff,      body_in;
   logic                     malformed_ff, malformed_in;

   // output register and skid
   logic            rsp_valid_ff,  rsp_valid_in;
   rsp_payload_type rsp_ff,        rsp_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_ff,       skid_in;

   // per-beat working values
   logic                       accept;
   logic                       pop;
   logic                       push;
   logic [7:0]                 b;
   logic [7:0]                 prev;
   logic [31:0]                window;
   logic [23:0]                cur_recent;
   logic [HEADER_COUNT_BITS:0] cur_cnt;
   logic                       cur_done;
   line_type                   cur_line;
   line_type                   after_cr;
   logic                       cur_found;
   logic [62:0]                cur_body;
   logic                       cur_malformed;
   logic                       bad;
   rsp_payload_type            result;

   assign req_ready   = !skid_valid_ff;
   assign accept      = req_valid && req_ready;
   assign pop         = rsp_valid_ff && rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Scan step: a first_of_message beat sees the reset state.
   always_comb begin
      b             = req_payload.data_byte;
      cur_recent    = req_payload.first_of_message ? '0 : recent_ff;
      cur_cnt       = req_payload.first_of_message ? '0 : hdr_cnt_ff;
      cur_done      = req_payload.first_of_message ? 1'b0 : done_ff;
      cur_line      = req_payload.first_of_message ? line_clear() : line_ff;
      cur_found     = req_payload.first_of_message ? 1'b0 : found_ff;
      cur_body      = req_payload.first_of_message ? '0 : body_ff;
      cur_malformed = req_payload.first_of_message ? 1'b0 : malformed_ff;

      prev   = cur_recent[7:0];
      window = {cur_recent, b};

      recent_in    = window[23:0];
      hdr_cnt_in   = cur_cnt[HEADER_COUNT_BITS] ? cur_cnt
                                                : cur_cnt + (HEADER_COUNT_BITS+1)'(1);
      line_in      = cur_line;
      found_in     = cur_found;
      body_in      = cur_body;
      malformed_in = cur_malformed;
      after_cr     = (prev == ChCr) ? line_cr(cur_line, cur_found) : cur_line;

      if (b == ChLf && prev == ChCr) begin
         // line end: take the first length line, then start a new line
         if (!cur_found && cur_line.matching
             && cur_line.pos > 5'(NameLen)) begin
            found_in = 1'b1;
            if (cur_line.bad || cur_line.digits == 5'd0) begin
               malformed_in = 1'b1;
            end else begin
               body_in = cur_line.acc;
            end
         end
         line_in = line_clear();
      end else if (b != ChCr) begin
         line_in = line_char(after_cr, b, cur_found, 5'(MAX_VALUE_CHARS));
      end else begin
         line_in = after_cr;   // this CR is held back; the byte after it decides its role
      end

      // end of headers: the blank line cannot itself be a length line,
      // so the current malformed and body values are final
      done_in = (window == HeaderEnd);
      bad     = cur_malformed || hdr_cnt_in[HEADER_COUNT_BITS];
      result.status       = bad;
      result.total_length = bad ? 64'd0
                                : 64'(hdr_cnt_in) + {1'b0, cur_body};
      push = accept && !cur_done && done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff    <= '0;
         hdr_cnt_ff   <= '0;
         done_ff      <= 1'b0;
         line_ff      <= line_clear();
         found_ff     <= 1'b0;
         body_ff      <= '0;
         malformed_ff <= 1'b0;
      end else if (accept && !cur_done) begin
         recent_ff    <= recent_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         done_ff      <= done_in;
         line_ff      <= line_in;
         found_ff     <= found_in;
         body_ff      <= body_in;
         malformed_ff <= malformed_in;
      end
   end

   // Output register plus skid; the skid only fills while rsp is stalled.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
